// ===== rtl/cell_group_range_matcher_defines.svh =====
// ============================================================================
// cell_group_range_matcher_defines.svh
// Assertion macros shared by the matcher RTL.
// ============================================================================
`ifndef CELL_GROUP_RANGE_MATCHER_DEFINES_SVH
`define CELL_GROUP_RANGE_MATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define CGRM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cgrm assertion failed");

// next-cycle implication, checked out of reset
`define CGRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cgrm assertion failed");

`else

`define CGRM_ASSERT_IMPL(label, ante, cons)
`define CGRM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/cgrm_pkg.sv =====
// ============================================================================
// cgrm_pkg
// Types, constants and helpers for the cell group range matcher.
// ============================================================================
package cgrm_pkg;

    localparam int MAX_GROUPS_DEF = 16;

    localparam int LAYER_W  = 2;
    localparam int REGION_W = 3;
    localparam int ETA_W    = 9;
    localparam int PHI_W    = 8;
    localparam int BOUND_W  = 9;

    localparam logic [BOUND_W-1:0] LAYER_MAX  = 9'd3;
    localparam logic [BOUND_W-1:0] REGION_MAX = 9'd7;
    localparam logic [BOUND_W-1:0] ETA_MAX    = 9'd511;
    localparam logic [BOUND_W-1:0] PHI_MAX    = 9'd255;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;
    localparam int COUNT_W   = 5;
    localparam int GIDX_W    = 4;

    // word select codes
    localparam logic [2:0] WS_MASKS  = 3'd0;
    localparam logic [2:0] WS_LAYER  = 3'd1;
    localparam logic [2:0] WS_REGION = 3'd2;
    localparam logic [2:0] WS_ETA    = 3'd3;
    localparam logic [2:0] WS_PHI    = 3'd4;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // subdetector codes
    localparam logic [2:0] SC_EMB     = 3'd1;
    localparam logic [2:0] SC_EMEC_IN = 3'd2;
    localparam logic [2:0] SC_EMEC_OU = 3'd3;
    localparam logic [2:0] SC_HEC     = 3'd4;
    localparam logic [2:0] SC_FCAL    = 3'd5;

    // input tdata layout, last field in the low bits
    typedef struct packed {
        logic [4:0]         pad;
        logic [PHI_W-1:0]   cell_phi;
        logic [ETA_W-1:0]   cell_eta;
        logic [REGION_W-1:0] cell_region;
        logic [LAYER_W-1:0] cell_layer;
        logic               cell_side;
        logic [2:0]         cell_subcalo;
        logic [BOUND_W-1:0] bound_high;
        logic [BOUND_W-1:0] bound_low;
        logic [2:0]         word_select;
        logic [3:0]         entry_index;
    } t_s_data;

    typedef struct packed {
        logic [2:0]          subcalo;
        logic                side;
        logic [LAYER_W-1:0]  layer;
        logic [REGION_W-1:0] region;
        logic [ETA_W-1:0]    eta;
        logic [PHI_W-1:0]    phi;
    } t_cell;

    typedef struct packed {
        logic [4:0]          subcalo_mask;
        logic [1:0]          side_mask;
        logic [LAYER_W-1:0]  layer_lo;
        logic [LAYER_W-1:0]  layer_hi;
        logic [REGION_W-1:0] region_lo;
        logic [REGION_W-1:0] region_hi;
        logic [ETA_W-1:0]    eta_lo;
        logic [ETA_W-1:0]    eta_hi;
        logic [PHI_W-1:0]    phi_lo;
        logic [PHI_W-1:0]    phi_hi;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
    } t_pair;

    // low bound past the field range yields an empty range (lo = max, hi = 0)
    function automatic t_pair clamp_pair(logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi,
                                         logic [BOUND_W-1:0] max);
        t_pair p;
        p.lo = lo;
        p.hi = hi;
        if (lo > max) begin
            p.lo = max;
            p.hi = '0;
        end else if (hi > max) begin
            p.hi = max;
        end
        return p;
    endfunction

endpackage

// ===== rtl/cell_group_range_matcher.sv =====
// ============================================================================
// cell_group_range_matcher
// Rule group table with a last-match lookup for decoded calorimeter cells.
// ============================================================================
// Usage:
//   Slave stream (i_s_*) carries one item per transfer; tuser selects a
//   lookup (0) or a write of one entry word (1). Master stream (o_m_*)
//   returns one result per item: tuser = found, tdata = group index.
//   The cfg channel sets the number of groups in use; write it only while
//   the block is idle.
//   A write item reads the entry and writes it back merged. A lookup
//   scans the table through one RAM read port, one group per cycle,
//   over the first min(group count, MAX_GROUPS) groups; a lookup with no
//   group in use, and a write that stores nothing, skip the table.
//   One item is in flight at a time;
//   a finished result sits in the output register, so the next item is
//   taken while it waits for the receiver.
//   Reset clears the group count and all control state; table contents
//   stay unknown until written. When the receiver stalls with a result
//   still held, the next result stays in the scan unit and no item is
//   taken until it moves to the output register.
// ============================================================================
`include "cell_group_range_matcher_defines.svh"

module cell_group_range_matcher #(
    parameter int MAX_GROUPS = cgrm_pkg::MAX_GROUPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: entry_index, word_select, bound_low, bound_high, cell_subcalo,
    //        cell_side, cell_layer, cell_region, cell_eta, cell_phi, zero pad
    input  logic [cgrm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_s_tuser,   // cmd
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [cgrm_pkg::M_TDATA_W-1:0]   o_m_tdata,   // group_index, zero pad
    output logic                             o_m_tuser,   // found
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cgrm_pkg::COUNT_W-1:0]     i_cfg_data   // group_count
);
    import cgrm_pkg::*;

    localparam int AW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW0 = $clog2(MAX_GROUPS + 1);
    localparam int NW  = (CW0 > COUNT_W) ? CW0 : COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRRD  = 6'b000010,
        S_WRWB  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [COUNT_W-1:0]  r_count;
    logic [AW-1:0]       r_entry, n_entry;
    logic [2:0]          r_word, n_word;
    logic [BOUND_W-1:0]  r_lo, n_lo;
    logic [BOUND_W-1:0]  r_hi, n_hi;
    t_cell               r_cell, n_cell;
    logic [AW-1:0]       r_addr, n_addr;
    logic [AW-1:0]       r_last, n_last;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pidx, n_pidx;
    logic                r_found, n_found;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [GIDX_W-1:0]   r_out_idx, n_out_idx;

    t_s_data             s_in;
    logic                s_accept;
    logic                out_free;
    logic [NW-1:0]       gc_ext;
    logic [NW-1:0]       n_eff;
    logic                entry_ok;
    logic                word_ok;

    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    t_entry              ram_rdata;
    t_entry              ram_wdata;
    logic                hit;
    t_pair               pair;

    assign s_in     = t_s_data'(i_s_tdata);
    assign s_accept = i_s_tvalid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_m_tready;

    assign gc_ext   = NW'(r_count);
    assign n_eff    = (gc_ext > NW'(MAX_GROUPS)) ? NW'(MAX_GROUPS) : gc_ext;
    assign entry_ok = (32'(s_in.entry_index) < MAX_GROUPS);
    assign word_ok  = (s_in.word_select <= WS_PHI);

    cgrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_GROUPS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_entry),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cgrm_match u_match (
        .i_entry (ram_rdata),
        .i_cell  (r_cell),
        .o_hit   (hit)
    );

    // merge one word into the entry read back from the table
    always_comb begin
        ram_wdata = ram_rdata;
        pair      = '0;
        unique case (r_word)
            WS_MASKS: begin
                ram_wdata.subcalo_mask = r_lo[4:0];
                ram_wdata.side_mask    = r_hi[1:0];
            end
            WS_LAYER: begin
                pair = clamp_pair(r_lo, r_hi, LAYER_MAX);
                ram_wdata.layer_lo = LAYER_W'(pair.lo);
                ram_wdata.layer_hi = LAYER_W'(pair.hi);
            end
            WS_REGION: begin
                pair = clamp_pair(r_lo, r_hi, REGION_MAX);
                ram_wdata.region_lo = REGION_W'(pair.lo);
                ram_wdata.region_hi = REGION_W'(pair.hi);
            end
            WS_ETA: begin
                pair = clamp_pair(r_lo, r_hi, ETA_MAX);
                ram_wdata.eta_lo = ETA_W'(pair.lo);
                ram_wdata.eta_hi = ETA_W'(pair.hi);
            end
            WS_PHI: begin
                pair = clamp_pair(r_lo, r_hi, PHI_MAX);
                ram_wdata.phi_lo = PHI_W'(pair.lo);
                ram_wdata.phi_hi = PHI_W'(pair.hi);
            end
            default: begin
                ram_wdata = ram_rdata;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_entry     = r_entry;
        n_word      = r_word;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_cell      = r_cell;
        n_addr      = r_addr;
        n_last      = r_last;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_found     = r_found;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        ram_we      = 1'b0;
        ram_raddr   = (r_state == S_WRRD) ? r_entry : r_addr;

        // compare stage: data for r_pidx is on the RAM output now
        if (r_pend && hit) begin
            n_found = 1'b1;
            n_idx   = r_pidx;
        end

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_entry = AW'(s_in.entry_index);
                    n_word  = s_in.word_select;
                    n_lo    = s_in.bound_low;
                    n_hi    = s_in.bound_high;
                    n_cell  = '{subcalo: s_in.cell_subcalo, side: s_in.cell_side,
                                layer: s_in.cell_layer, region: s_in.cell_region,
                                eta: s_in.cell_eta, phi: s_in.cell_phi};
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_addr  = '0;
                    n_last  = AW'(n_eff - NW'(1));
                    if (i_s_tuser == CMD_WRITE) begin
                        n_state = (entry_ok && word_ok) ? S_WRRD : S_DONE;
                    end else begin
                        n_state = (n_eff == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_WRRD: begin
                n_state = S_WRWB;
            end
            S_WRWB: begin
                ram_we  = 1'b1;
                n_state = S_DONE;
            end
            S_SCAN: begin
                n_pend = 1'b1;
                n_pidx = r_addr;
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_idx   = GIDX_W'(r_idx);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_idx       <= n_idx;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry     <= n_entry;
        r_word      <= n_word;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_cell      <= n_cell;
        r_addr      <= n_addr;
        r_last      <= n_last;
        r_pidx      <= n_pidx;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_found;
    assign o_m_tdata   = {{(M_TDATA_W - GIDX_W){1'b0}}, r_out_idx};
    assign o_cfg_ready = 1'b1;

    `CGRM_ASSERT_IMPL(a_nofound_zero_idx, o_m_tvalid && !o_m_tuser, o_m_tdata == '0)
    `CGRM_ASSERT_IMPL(a_write_no_found, r_state == S_WRWB, !r_found && !r_pend)
    `CGRM_ASSERT_IMPL(a_scan_in_range, r_state == S_SCAN, r_addr <= r_last)
    `CGRM_ASSERT_IMPL(a_pend_in_scan, r_pend, r_state == S_SCAN || r_state == S_DRAIN)
    `CGRM_ASSERT_NEXT(a_accept_busy, s_accept, !o_s_tready)

endmodule

// ===== rtl/cgrm_ram.sv =====
// ============================================================================
// cgrm_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module cgrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cgrm_match.sv =====
// ============================================================================
// cgrm_match
// Compares one group entry against the decoded fields of a cell.
// ============================================================================
module cgrm_match (
    input  cgrm_pkg::t_entry i_entry,
    input  cgrm_pkg::t_cell  i_cell,
    output logic             o_hit
);
    import cgrm_pkg::*;

    logic sc_hit;
    logic side_hit;
    logic rng_hit;

    always_comb begin
        unique case (i_cell.subcalo)
            SC_EMB:     sc_hit = i_entry.subcalo_mask[0];
            SC_EMEC_IN: sc_hit = i_entry.subcalo_mask[1];
            SC_EMEC_OU: sc_hit = i_entry.subcalo_mask[2];
            SC_HEC:     sc_hit = i_entry.subcalo_mask[3];
            SC_FCAL:    sc_hit = i_entry.subcalo_mask[4];
            default:    sc_hit = 1'b0;   // not LAr or unknown code
        endcase
    end

    assign side_hit = i_cell.side ? i_entry.side_mask[1] : i_entry.side_mask[0];

    assign rng_hit = (i_cell.layer  >= i_entry.layer_lo)  && (i_cell.layer  <= i_entry.layer_hi)
                  && (i_cell.region >= i_entry.region_lo) && (i_cell.region <= i_entry.region_hi)
                  && (i_cell.eta    >= i_entry.eta_lo)    && (i_cell.eta    <= i_entry.eta_hi)
                  && (i_cell.phi    >= i_entry.phi_lo)    && (i_cell.phi    <= i_entry.phi_hi);

    assign o_hit = sc_hit && side_hit && rng_hit;

endmodule

// ===== bench/cell_group_range_matcher_tb.sv =====
// ============================================================================
// cell_group_range_matcher_tb
// Self-checking bench for the rule group table and its last-match lookup.
// The table and the group count are mirrored here, and the expected
// found/index pair is worked out for every item as it is accepted. Random
// lookups are mostly aimed inside the bounds of a chosen group, so that
// overlapping groups and the last-match rule get exercised.
// ============================================================================
module cell_group_range_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgrm_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct {
        logic       cmd;
        logic [3:0] entry;
        logic [2:0] word;
        logic [8:0] lo;
        logic [8:0] hi;
        logic [2:0] subcalo;
        logic       side;
        logic [1:0] layer;
        logic [2:0] region;
        logic [8:0] eta;
        logic [7:0] phi;
    } t_match_req;

    typedef struct {
        logic       found;
        logic [3:0] gidx;
    } t_match_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data;

    // mirror of the group table and the count register
    logic [4:0]   tbl_sc_mask  [MAX_GROUPS_DEF];
    logic [1:0]   tbl_side_mask[MAX_GROUPS_DEF];
    logic [1:0]   tbl_layer_lo [MAX_GROUPS_DEF];
    logic [1:0]   tbl_layer_hi [MAX_GROUPS_DEF];
    logic [2:0]   tbl_region_lo[MAX_GROUPS_DEF];
    logic [2:0]   tbl_region_hi[MAX_GROUPS_DEF];
    logic [8:0]   tbl_eta_lo   [MAX_GROUPS_DEF];
    logic [8:0]   tbl_eta_hi   [MAX_GROUPS_DEF];
    logic [7:0]   tbl_phi_lo   [MAX_GROUPS_DEF];
    logic [7:0]   tbl_phi_hi   [MAX_GROUPS_DEF];
    int unsigned  groups_in_use;

    t_match_res   pending_matches[$];
    int           mismatch_count;
    int           tx_gap_max;
    int           tx_burst_left;
    int           rx_hold_cycles;

    cell_group_range_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned field_max(logic [2:0] word);
        case (word)
            WS_LAYER:  return LAYER_MAX;
            WS_REGION: return REGION_MAX;
            WS_ETA:    return ETA_MAX;
            WS_PHI:    return PHI_MAX;
            default:   return 511;
        endcase
    endfunction

    // a low bound past the range gives an empty range (max..0)
    function automatic void clip_range(input int unsigned lo, input int unsigned hi,
                                       input int unsigned maxv,
                                       output int unsigned lo_o, output int unsigned hi_o);
        if (lo > maxv) begin
            lo_o = maxv;
            hi_o = 0;
        end else begin
            lo_o = lo;
            hi_o = (hi > maxv) ? maxv : hi;
        end
    endfunction

    function automatic bit group_hit(int g, t_match_req it);
        if (it.subcalo < SC_EMB || it.subcalo > SC_FCAL) return 1'b0;
        if (!tbl_sc_mask[g][it.subcalo - SC_EMB]) return 1'b0;
        if (!tbl_side_mask[g][it.side]) return 1'b0;
        if (it.layer < tbl_layer_lo[g] || it.layer > tbl_layer_hi[g]) return 1'b0;
        if (it.region < tbl_region_lo[g] || it.region > tbl_region_hi[g]) return 1'b0;
        if (it.eta < tbl_eta_lo[g] || it.eta > tbl_eta_hi[g]) return 1'b0;
        if (it.phi < tbl_phi_lo[g] || it.phi > tbl_phi_hi[g]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_match_res predict_match(t_match_req it);
        t_match_res  r;
        int unsigned l, h, n;
        r.found = 1'b0;
        r.gidx  = '0;
        if (it.cmd == CMD_WRITE) begin
            clip_range(it.lo, it.hi, field_max(it.word), l, h);
            case (it.word)
                WS_MASKS: begin
                    tbl_sc_mask[it.entry]   = it.lo[4:0];
                    tbl_side_mask[it.entry] = it.hi[1:0];
                end
                WS_LAYER: begin
                    tbl_layer_lo[it.entry] = l[1:0];
                    tbl_layer_hi[it.entry] = h[1:0];
                end
                WS_REGION: begin
                    tbl_region_lo[it.entry] = l[2:0];
                    tbl_region_hi[it.entry] = h[2:0];
                end
                WS_ETA: begin
                    tbl_eta_lo[it.entry] = l[8:0];
                    tbl_eta_hi[it.entry] = h[8:0];
                end
                WS_PHI: begin
                    tbl_phi_lo[it.entry] = l[7:0];
                    tbl_phi_hi[it.entry] = h[7:0];
                end
                default: ;   // unused word selects write nothing
            endcase
        end else begin
            n = (groups_in_use > MAX_GROUPS_DEF) ? MAX_GROUPS_DEF : groups_in_use;
            for (int g = 0; g < n; g++) begin
                if (group_hit(g, it)) begin
                    r.found = 1'b1;
                    r.gidx  = g[3:0];
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(t_match_req it);
        t_s_data d;
        int      gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 12);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        d               = '0;
        d.entry_index   = it.entry;
        d.word_select   = it.word;
        d.bound_low     = it.lo;
        d.bound_high    = it.hi;
        d.cell_subcalo  = it.subcalo;
        d.cell_side     = it.side;
        d.cell_layer    = it.layer;
        d.cell_region   = it.region;
        d.cell_eta      = it.eta;
        d.cell_phi      = it.phi;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= it.cmd;
        do @(posedge i_clk); while (!o_s_tready);
        pending_matches.insert(pending_matches.size(), predict_match(it));
    endtask

    task automatic write_word(int entry, logic [2:0] word, int lo, int hi);
        t_match_req it;
        it         = '{default: '0};
        it.cmd     = CMD_WRITE;
        it.entry   = entry[3:0];
        it.word    = word;
        it.lo      = lo[8:0];
        it.hi      = hi[8:0];
        it.subcalo = 3'($urandom);
        it.side    = 1'($urandom);
        it.layer   = 2'($urandom);
        it.region  = 3'($urandom);
        it.eta     = 9'($urandom);
        it.phi     = 8'($urandom);
        push_item(it);
    endtask

    task automatic lookup_cell(int subcalo, int side, int layer, int region,
                               int eta, int phi);
        t_match_req it;
        it         = '{default: '0};
        it.cmd     = CMD_LOOKUP;
        it.entry   = 4'($urandom);
        it.word    = 3'($urandom);
        it.lo      = 9'($urandom);
        it.hi      = 9'($urandom);
        it.subcalo = subcalo[2:0];
        it.side    = side[0];
        it.layer   = layer[1:0];
        it.region  = region[2:0];
        it.eta     = eta[8:0];
        it.phi     = phi[7:0];
        push_item(it);
    endtask

    // count changes only with the block idle
    task automatic write_group_count(int count);
        i_s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count[COUNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        groups_in_use = count[COUNT_W-1:0];
    endtask

    task automatic pick_bounds(input logic [2:0] word, output int lo, output int hi);
        int unsigned maxv;
        maxv = field_max(word);
        if (word == WS_MASKS) begin
            lo = $urandom_range(0, 511);
            hi = $urandom_range(0, 511);
            if ($urandom_range(0, 2) != 0) lo[4:0] = 5'h1F ^ (5'h1 << $urandom_range(0, 5));
            if (hi[1:0] == 2'b00 && $urandom_range(0, 1)) hi[1:0] = 2'b11;
            return;
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                lo = 0;
                hi = 511;
            end
            7: begin
                lo = $urandom_range(0, 511);
                hi = $urandom_range(0, 511);
            end
            8: begin
                lo = (maxv < 511) ? $urandom_range(maxv + 1, 511) : $urandom_range(0, 511);
                hi = $urandom_range(0, 511);
            end
            9: begin
                lo = $urandom_range(0, maxv);
                hi = $urandom_range(0, maxv);
            end
            default: begin
                lo = $urandom_range(0, maxv);
                hi = $urandom_range(lo, maxv);
            end
        endcase
    endtask

    task automatic load_random_entry(int entry);
        int lo, hi;
        for (int w = WS_MASKS; w <= WS_PHI; w++) begin
            pick_bounds(w[2:0], lo, hi);
            write_word(entry, w[2:0], lo, hi);
        end
    endtask

    function automatic int aim_value(int lo, int hi, int maxv);
        if (lo <= hi) return $urandom_range(lo, hi);
        return $urandom_range(0, maxv);
    endfunction

    // mostly aimed inside one group's bounds, the rest unrestricted
    task automatic random_lookup();
        int g, sc;
        g = $urandom_range(0, MAX_GROUPS_DEF - 1);
        if ($urandom_range(0, 9) < 7) begin
            sc = $urandom_range(1, 5);
            repeat (5) if (!tbl_sc_mask[g][sc - 1]) sc = sc % 5 + 1;
            lookup_cell(sc,
                        (tbl_side_mask[g] == 2'b01) ? 0 :
                        (tbl_side_mask[g] == 2'b10) ? 1 : $urandom_range(0, 1),
                        aim_value(tbl_layer_lo[g], tbl_layer_hi[g], LAYER_MAX),
                        aim_value(tbl_region_lo[g], tbl_region_hi[g], REGION_MAX),
                        aim_value(tbl_eta_lo[g], tbl_eta_hi[g], ETA_MAX),
                        aim_value(tbl_phi_lo[g], tbl_phi_hi[g], PHI_MAX));
        end else begin
            lookup_cell($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 3),
                        $urandom_range(0, 7), $urandom_range(0, 511), $urandom_range(0, 255));
        end
    endtask

    task automatic random_write();
        logic [2:0] word;
        int         lo, hi;
        word = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
        pick_bounds(word, lo, hi);
        write_word($urandom_range(0, MAX_GROUPS_DEF - 1), word, lo, hi);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // count is zero out of reset: nothing may match, and the table is never scanned
    task automatic test_empty_table();
        lookup_cell(0, 0, 0, 0, 0, 0);
        lookup_cell(7, 1, 3, 7, 511, 255);
        for (int sc = SC_EMB; sc <= SC_FCAL; sc++)
            lookup_cell(sc, sc % 2, sc % 4, sc, sc * 100, sc * 50);
        write_word(0, 3'd5, 511, 511);
        write_word(15, 3'd6, 0, 0);
        write_word(7, 3'd7, 511, 0);
    endtask

    task automatic test_table_load();
        // entry 0 matches everything, high bounds past range get clamped
        write_word(0, WS_MASKS, 511, 511);
        write_word(0, WS_LAYER, 0, 511);
        write_word(0, WS_REGION, 0, 511);
        write_word(0, WS_ETA, 0, 511);
        write_word(0, WS_PHI, 0, 511);
        for (int g = 1; g < MAX_GROUPS_DEF - 2; g++) load_random_entry(g);
        // entry 14: low bounds past range, so it can never match
        write_word(14, WS_MASKS, 31, 3);
        write_word(14, WS_LAYER, 4, 9);
        write_word(14, WS_REGION, 0, 511);
        write_word(14, WS_ETA, 0, 511);
        write_word(14, WS_PHI, 256, 0);
        // entry 15: only the top corner cell on the positive EMB side
        write_word(15, WS_MASKS, 9'h001, 9'h002);
        write_word(15, WS_LAYER, 3, 3);
        write_word(15, WS_REGION, 7, 7);
        write_word(15, WS_ETA, 511, 511);
        write_word(15, WS_PHI, 255, 300);
    endtask

    task automatic test_directed_lookups();
        write_group_count(MAX_GROUPS_DEF);
        lookup_cell(SC_EMB, 1, 3, 7, 511, 255);      // last match wins
        lookup_cell(SC_EMB, 0, 3, 7, 511, 255);      // wrong side for entry 15
        lookup_cell(SC_FCAL, 1, 3, 7, 511, 255);
        lookup_cell(SC_HEC, 0, 0, 0, 0, 0);
        lookup_cell(0, 1, 3, 7, 511, 255);           // unknown subdetectors
        lookup_cell(6, 1, 3, 7, 511, 255);
        lookup_cell(7, 0, 0, 0, 0, 0);
        write_group_count(31);                       // more than the table holds
        lookup_cell(SC_EMB, 1, 3, 7, 511, 255);
        lookup_cell(SC_EMEC_IN, 0, 1, 2, 200, 100);
        write_group_count(1);
        lookup_cell(SC_EMB, 1, 3, 7, 511, 255);
        lookup_cell(SC_EMEC_OU, 0, 0, 0, 0, 0);
        write_word(3, WS_ETA, 10, 20);
        lookup_cell(SC_EMB, 1, 2, 3, 15, 128);
    endtask

    // receiver stops for a long while, the sender keeps offering
    task automatic test_backpressure();
        write_group_count(MAX_GROUPS_DEF);
        tx_gap_max     = 0;
        rx_hold_cycles = 400;
        repeat (40) random_lookup();
        tx_gap_max = 20;
    endtask

    task automatic test_random_traffic();
        int counts[8];
        counts = '{MAX_GROUPS_DEF, 1, 0, 31, 0, 8, MAX_GROUPS_DEF, 0};
        counts[4] = $urandom_range(1, MAX_GROUPS_DEF);
        counts[7] = $urandom_range(2, MAX_GROUPS_DEF);
        for (int p = 0; p < 8; p++) begin
            write_group_count(counts[p]);
            tx_gap_max = (p % 3 == 0) ? 0 : 20;
            repeat (150) begin
                if ($urandom_range(0, 99) < 15) random_write();
                else random_lookup();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_match_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_matches.size() == 0) begin
                $error("result transfer with nothing pending: found=%0d group_index=%0d",
                       o_m_tuser, o_m_tdata[GIDX_W-1:0]);
                mismatch_count++;
            end else begin
                want = pending_matches.pop_front();
                if (o_m_tuser !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tdata[GIDX_W-1:0] !== want.gidx) begin
                    $error("group_index: expected %0d, got %0d",
                           want.gidx, o_m_tdata[GIDX_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: changing stall pattern, plus an optional long hold
    initial begin : rx_stall
        int mode, left, tick;
        mode       = 0;
        left       = 0;
        tick       = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 200);
                end
                left--;
                tick++;
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_tready <= ($urandom_range(0, 7) == 0);
                    default: i_m_tready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    initial begin
        #5ms;
        $display("cell_group_range_matcher test failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = CMD_LOOKUP;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        groups_in_use  = 0;
        mismatch_count = 0;
        tx_gap_max     = 20;
        tx_burst_left  = 0;
        rx_hold_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_table_load();
        test_directed_lookups();
        test_backpressure();
        test_random_traffic();

        i_s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("cell_group_range_matcher test passed");
        end else begin
            $display("cell_group_range_matcher test failed");
        end
        $finish;
    end

endmodule
